// File: hdl/cartridge_bank_switch_mapper_assert.svh
// Assertion helpers for the cartridge bank-switch mapper.
// Each macro checks one implication on the rising clock edge and is
// switched off while reset is asserted.
`ifndef CARTRIDGE_BANK_SWITCH_MAPPER_ASSERT_SVH
`define CARTRIDGE_BANK_SWITCH_MAPPER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define CBSM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cbsm assertion failed");

// Next-cycle implication.
`define CBSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cbsm assertion failed");

`else

`define CBSM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CBSM_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: hdl/cbsm_pkg.sv
package cbsm_pkg;

  // Field widths
  localparam int unsigned FuncW    = 2;
  localparam int unsigned AddrW    = 16;
  localparam int unsigned DataW    = 8;
  localparam int unsigned TargetW  = 2;
  localparam int unsigned OffsetW  = 17;
  localparam int unsigned MirrorW  = 2;
  localparam int unsigned CmdW     = 3;
  localparam int unsigned ChrPageW = 7;
  localparam int unsigned PrgBankW = 4;
  localparam int unsigned ChrSlots = 8;
  localparam int unsigned PrgSlots = 2;

  // Configuration port
  localparam int unsigned PaddrW = 4;
  localparam int unsigned PdataW = 32;

  // Item function codes
  localparam logic [FuncW-1:0] FuncCpuWrite = 2'd0;
  localparam logic [FuncW-1:0] FuncCpuRead  = 2'd1;
  localparam logic [FuncW-1:0] FuncPpuXlate = 2'd2;

  // Result target codes
  localparam logic [TargetW-1:0] TargetNone = 2'd0;
  localparam logic [TargetW-1:0] TargetPrg  = 2'd1;
  localparam logic [TargetW-1:0] TargetChr  = 2'd2;

  // Mirroring codes
  localparam logic [MirrorW-1:0] MirrorHeader  = 2'd0;
  localparam logic [MirrorW-1:0] MirrorOneLow  = 2'd1;
  localparam logic [MirrorW-1:0] MirrorOneHigh = 2'd2;

  // Bank commands
  localparam logic [CmdW-1:0] CmdChr2k0 = 3'd0;
  localparam logic [CmdW-1:0] CmdChr2k1 = 3'd1;
  localparam logic [CmdW-1:0] CmdChr1k0 = 3'd2;
  localparam logic [CmdW-1:0] CmdChr1k1 = 3'd3;
  localparam logic [CmdW-1:0] CmdChr1k2 = 3'd4;
  localparam logic [CmdW-1:0] CmdChr1k3 = 3'd5;
  localparam logic [CmdW-1:0] CmdPrg0   = 3'd6;
  localparam logic [CmdW-1:0] CmdPrg1   = 3'd7;

  // 1KB commands land in slots four to seven
  localparam logic [CmdW-1:0] Chr1kSlotOffset = 3'd2;

  // Configuration register indexes
  localparam logic [1:0] RegVariant  = 2'd0;
  localparam logic [1:0] RegPrgPages = 2'd1;
  localparam logic [1:0] RegChrPages = 2'd2;

  // Configuration reset values
  localparam logic       VariantRst  = 1'b0;
  localparam logic [3:0] PrgPagesRst = 4'd8;
  localparam logic [7:0] ChrPagesRst = 8'd128;

  typedef struct packed {
    logic       variant;
    logic [3:0] prg_pages;
    logic [7:0] chr_pages;
  } cfg_t;

  // Clamp the 16KB page count into 1..8.
  function automatic logic [3:0] prg_clamp(input logic [3:0] pages);
    logic [3:0] p;
    p = pages;
    if (p == 4'd0) p = 4'd1;
    if (p > 4'd8) p = 4'd8;
    return p;
  endfunction

  // Page mask: largest power of two not above the count, within 8..128, minus one.
  function automatic logic [ChrPageW-1:0] chr_mask(input logic [7:0] pages);
    logic [ChrPageW-1:0] m;
    if (pages[7])      m = 7'h7F;
    else if (pages[6]) m = 7'h3F;
    else if (pages[5]) m = 7'h1F;
    else if (pages[4]) m = 7'h0F;
    else               m = 7'h07;
    return m;
  endfunction

  // 8KB bank modulo the bank count (2..16); restoring steps, quotient below 8.
  function automatic logic [PrgBankW-1:0] prg_bank_mod(input logic [PrgBankW-1:0] bank,
                                                       input logic [3:0] pages);
    logic [7:0] r;
    logic [7:0] d;
    r = {4'd0, bank};
    for (int k = 2; k >= 0; k--) begin
      d = {3'd0, pages, 1'b0} << k;
      if (r >= d) r = r - d;
    end
    return r[PrgBankW-1:0];
  endfunction

endpackage

// File: hdl/cbsm_if.sv
interface cbsm_in_if;
  import cbsm_pkg::*;

  logic             valid;
  logic             ready;
  logic [FuncW-1:0] func;
  logic [AddrW-1:0] bus_address;
  logic [DataW-1:0] write_data;

  modport source (output valid, output func, output bus_address, output write_data,
                  input ready);
  modport sink   (input valid, input func, input bus_address, input write_data,
                  output ready);
endinterface

interface cbsm_out_if;
  import cbsm_pkg::*;

  logic               valid;
  logic               ready;
  logic [TargetW-1:0] target;
  logic [OffsetW-1:0] rom_offset;
  logic [MirrorW-1:0] mirror_mode;

  modport source (output valid, output target, output rom_offset, output mirror_mode,
                  input ready);
  modport sink   (input valid, input target, input rom_offset, input mirror_mode,
                  output ready);
endinterface

// File: hdl/cartridge_bank_switch_mapper.sv
// Cartridge bank-switch mapper (command/bank-register style, 2KB+1KB CHR, 8KB PRG).
// Channels: in_i takes one item per valid/ready handshake: func selects a CPU
//   write (bus_address at or above 0x8000 programs the banks), a CPU read
//   translate, or a PPU translate (low 14 address bits). out_o returns exactly
//   one result item per input item: target ROM, byte offset, current mirroring.
// Configuration: APB-style write/read port; registers sit at byte addresses 0
//   (variant), 4 (16KB program pages) and 8 (1KB character pages).
// Path: an accepted item is captured in the input register, and its result
//   is loaded into the output register once that register is free or being
//   drained; out_o.valid then rises.
// Throughput: one item per clock while out_o.ready is high; the input register
//   and the output register each hold one item, and the bank registers update
//   as a write leaves the input register, so the very next item already sees them.
// Reset: clears both pipeline valid bits, the command register, all bank
//   registers and the mirroring state, and loads the configuration defaults.
// Stall: while out_o.ready is low the result holds in the output register;
//   one more item is still taken into the input register, then in_i.ready drops.
module cartridge_bank_switch_mapper (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cbsm_pkg::PaddrW-1:0] paddr,
  input  logic [cbsm_pkg::PdataW-1:0] pwdata,
  output logic [cbsm_pkg::PdataW-1:0] prdata,
  output logic                        pready,
  cbsm_in_if.sink                     in_i,
  cbsm_out_if.source                  out_o
);
  import cbsm_pkg::*;

`include "cartridge_bank_switch_mapper_assert.svh"

  cfg_t cfg;

  cbsm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Input register
  logic             s1_valid_q;
  logic [FuncW-1:0] s1_func_q;
  logic [AddrW-1:0] s1_addr_q;
  logic [DataW-1:0] s1_data_q;

  // Output register
  logic               out_valid_q;
  logic [TargetW-1:0] out_target_q;
  logic [OffsetW-1:0] out_offset_q;
  logic [MirrorW-1:0] out_mirror_q;

  // Bank state and its next values
  logic [CmdW-1:0]     cmd_q, cmd_d;
  logic [ChrPageW-1:0] chr_page_q [ChrSlots];
  logic [ChrPageW-1:0] chr_page_d [ChrSlots];
  logic [PrgBankW-1:0] prg_bank_q [PrgSlots];
  logic [PrgBankW-1:0] prg_bank_d [PrgSlots];
  logic [MirrorW-1:0]  mirror_q, mirror_d;

  logic               adv_s1;
  logic               cmd_wr_en;
  logic [TargetW-1:0] target_d;
  logic [OffsetW-1:0] offset_d;

  // Derived configuration
  logic [3:0]          prg_pages;
  logic [2:0]          prg_last;
  logic [ChrPageW-1:0] chr_msk;
  logic [PrgBankW-1:0] prg_bank_sel;
  logic [ChrPageW-1:0] chr_page_sel;
  logic [5:0]          bank_val;
  logic [CmdW-1:0]     chr1k_slot;

  // Move the held item on when the output register is free or being drained.
  assign adv_s1     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || adv_s1;
  assign cmd_wr_en  = adv_s1 && (s1_func_q == FuncCpuWrite) && s1_addr_q[15] && !s1_addr_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_func_q <= in_i.func;
      s1_addr_q <= in_i.bus_address;
      s1_data_q <= in_i.write_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_s1) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_s1) begin
      out_target_q <= target_d;
      out_offset_q <= offset_d;
      out_mirror_q <= mirror_d;
    end
  end

  // Bank state commits only as its item leaves the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q    <= '0;
      mirror_q <= MirrorHeader;
      for (int i = 0; i < ChrSlots; i++) chr_page_q[i] <= '0;
      for (int i = 0; i < PrgSlots; i++) prg_bank_q[i] <= '0;
    end else if (adv_s1) begin
      cmd_q      <= cmd_d;
      mirror_q   <= mirror_d;
      chr_page_q <= chr_page_d;
      prg_bank_q <= prg_bank_d;
    end
  end

  assign prg_pages    = prg_clamp(cfg.prg_pages);
  assign prg_last     = 3'(prg_pages - 4'd1);
  assign chr_msk      = chr_mask(cfg.chr_pages);
  assign prg_bank_sel = prg_bank_mod(prg_bank_q[s1_addr_q[13]], prg_pages);
  assign chr_page_sel = chr_page_q[s1_addr_q[12:10]] & chr_msk;
  assign bank_val     = s1_data_q[5:0];
  assign chr1k_slot   = 3'(cmd_q + Chr1kSlotOffset);

  always_comb begin
    target_d   = TargetNone;
    offset_d   = '0;
    cmd_d      = cmd_q;
    mirror_d   = mirror_q;
    chr_page_d = chr_page_q;
    prg_bank_d = prg_bank_q;
    case (s1_func_q)
      FuncCpuWrite: begin
        if (s1_addr_q[15]) begin
          target_d = TargetPrg;
          if (s1_addr_q[0]) begin
            // Odd address: load the bank register picked by the command.
            case (cmd_q) inside
              CmdChr2k0, CmdChr2k1: begin
                chr_page_d[{1'b0, cmd_q[0], 1'b0}] = {1'b0, bank_val[5:1], 1'b0};
                chr_page_d[{1'b0, cmd_q[0], 1'b1}] = {1'b0, bank_val[5:1], 1'b1};
              end
              CmdChr1k0, CmdChr1k1, CmdChr1k2, CmdChr1k3: begin
                chr_page_d[chr1k_slot] = {1'b1, bank_val};
              end
              CmdPrg0, CmdPrg1: begin
                prg_bank_d[cmd_q[0]] = s1_data_q[3:0];
              end
              default: ;
            endcase
          end else begin
            // Even address: latch the command, optionally the mirroring.
            cmd_d = s1_data_q[2:0];
            if (cfg.variant) mirror_d = s1_data_q[6] ? MirrorOneLow : MirrorOneHigh;
          end
        end
      end
      FuncCpuRead: begin
        if (s1_addr_q[15]) begin
          target_d = TargetPrg;
          if (s1_addr_q[14]) offset_d = {prg_last, s1_addr_q[13:0]};
          else               offset_d = {prg_bank_sel, s1_addr_q[12:0]};
        end
      end
      FuncPpuXlate: begin
        // Pattern tables only; the nametable area is not ours.
        if (!s1_addr_q[13]) begin
          target_d = TargetChr;
          offset_d = {chr_page_sel, s1_addr_q[9:0]};
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.target      = out_target_q;
  assign out_o.rom_offset  = out_offset_q;
  assign out_o.mirror_mode = out_mirror_q;

  // A full pipeline with a stalled receiver must refuse input.
  `CBSM_ASSERT_IMPL(a_stall_blocks_input, clk_i, rst_ni, s1_valid_q && out_valid_q && !out_o.ready, !in_i.ready)
  // An item leaving the input register always shows up as a result.
  `CBSM_ASSERT_NEXT(a_advance_fills_output, clk_i, rst_ni, adv_s1, out_valid_q)
  // The command register moves only on a handled even-address write.
  `CBSM_ASSERT_IMPL(a_cmd_only_on_even_write, clk_i, rst_ni, !$stable(cmd_q), $past(cmd_wr_en))

endmodule

// File: hdl/cbsm_cfg.sv
module cbsm_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cbsm_pkg::PaddrW-1:0] paddr,
  input  logic [cbsm_pkg::PdataW-1:0] pwdata,
  output logic [cbsm_pkg::PdataW-1:0] prdata,
  output logic                        pready,
  output cbsm_pkg::cfg_t              cfg_o
);
  import cbsm_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.variant   <= VariantRst;
      cfg_q.prg_pages <= PrgPagesRst;
      cfg_q.chr_pages <= ChrPagesRst;
    end else if (wr_en) begin
      case (reg_idx)
        RegVariant:  cfg_q.variant   <= pwdata[0];
        RegPrgPages: cfg_q.prg_pages <= pwdata[3:0];
        RegChrPages: cfg_q.chr_pages <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegVariant:  prdata = {31'd0, cfg_q.variant};
      RegPrgPages: prdata = {28'd0, cfg_q.prg_pages};
      RegChrPages: prdata = {24'd0, cfg_q.chr_pages};
      default:     prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule
